/* hdl/pdr_pkg.sv */
// Shared types and constants for the pixel depth reducer and packer.
// No dependencies; used by every module in this folder.
`default_nettype none

package pdr_pkg;

	localparam int SampleWidth = 8;
	localparam int BpsWidth    = 4;
	localparam int LineWidthW  = 16;
	localparam int CfgIndexW   = 2;
	localparam int CfgDataW    = 16;

	localparam int DefMaxLineWidth = 65535;

	// Register indexes on the configuration port.
	localparam logic [CfgIndexW-1:0] REG_BITS_PER_SAMPLE = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_LINE_WIDTH      = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_INDEX_MODE      = 2'd2;

	localparam logic [BpsWidth-1:0]   RST_BITS_PER_SAMPLE = 4'd8;
	localparam logic [LineWidthW-1:0] RST_LINE_WIDTH      = 16'd1;

	// One packed output byte and its end-of-line flag.
	typedef struct packed {
		logic [7:0] packed_byte;
		logic       end_of_line;
	} result_t;

	// Up to two results produced by one pixel, first one in slot a.
	typedef struct packed {
		logic [1:0] count;
		result_t    a;
		result_t    b;
	} push_t;

endpackage

`default_nettype wire

/* hdl/pixel_depth_reduce_packer.sv */
// Top level of the pixel depth reducer and MSB-first byte packer.
// Depends on pdr_pkg, pdr_reduce and pdr_result_fifo.
//
// Usage:
// Pixels enter one per request on the s_axis channel (tdata = sample). Each
// sample is reduced to bits_per_sample bits, either scaled as a gray level
// (floor(s * (2^bps - 1) / 255)) or truncated as a palette index, and the
// values are packed into bytes with the first pixel in the most significant
// bits. Bytes leave on the m_axis channel; tlast marks the byte that closes
// a scanline. The last pixel of a line flushes any partial byte, zero padded.
// A pixel can yield two bytes: a full byte and then the flushed line end.
//
// Timing: one pixel is accepted per clock. The reduced sample is registered
// in the first stage, then packed and written into a four-entry result queue.
// The queue takes two results in one cycle, which lets a line-end pixel that
// gives two bytes pass without a bubble; the input stalls only when the queue
// cannot take two more results because the receiver holds tready low.
//
// Reset clears the packing state, empties the queue and sets bits_per_sample
// to 8, line_width to 1 and index_mode to 0. Configuration must be written by
// the user via cfg_we / cfg_index / cfg_data while the block is idle (not enforced).
`default_nettype none

module pixel_depth_reduce_packer #(
	parameter int MAX_LINE_WIDTH = pdr_pkg::DefMaxLineWidth
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration write port.
	input  wire logic                               cfg_we,
	input  wire logic [pdr_pkg::CfgIndexW-1:0]      cfg_index,
	input  wire logic [pdr_pkg::CfgDataW-1:0]       cfg_data,
	// Pixel input stream.
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [7:0]                         s_axis_tdata,  // [7:0] sample
	// Packed byte output stream.
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [7:0]                              m_axis_tdata,  // [7:0] packed_byte
	output logic                                    m_axis_tlast   // end_of_line
);

	localparam logic [pdr_pkg::LineWidthW-1:0] MaxWidth = pdr_pkg::LineWidthW'(MAX_LINE_WIDTH);

	// Configuration registers.
	logic [pdr_pkg::BpsWidth-1:0]   bps_q;
	logic [pdr_pkg::LineWidthW-1:0] width_q;
	logic                           index_mode_q;

	// Packing state.
	logic [7:0]                     acc_q;
	logic [2:0]                     filled_q;
	logic [pdr_pkg::LineWidthW-1:0] column_q;

	// First stage: reduced sample.
	logic                           valid_s1;
	logic [7:0]                     value_s1;

	logic [pdr_pkg::BpsWidth-1:0]   bps_eff;
	logic [pdr_pkg::LineWidthW-1:0] width_eff;
	logic [7:0]                     value;
	logic                           room_for_two;
	logic                           advance;
	logic                           in_accept;

	logic [4:0]                     total;
	logic [15:0]                    window;
	logic [pdr_pkg::LineWidthW-1:0] column_next;
	logic                           eol;
	logic [7:0]                     acc_next;
	logic [2:0]                     filled_next;
	pdr_pkg::push_t                 push;
	pdr_pkg::result_t               head;

	// Clamp the registers to their legal ranges.
	always_comb begin
		if (bps_q == '0) begin
			bps_eff = 4'd1;
		end else if (bps_q > 4'd8) begin
			bps_eff = 4'd8;
		end else begin
			bps_eff = bps_q;
		end
		if (width_q == '0 || width_q > MaxWidth) begin
			width_eff = MaxWidth;
		end else begin
			width_eff = width_q;
		end
	end

	pdr_reduce u_reduce (
		.sample     (s_axis_tdata),
		.bps        (bps_eff),
		.index_mode (index_mode_q),
		.value      (value)
	);

	assign advance       = valid_s1 && room_for_two;
	assign s_axis_tready = !valid_s1 || room_for_two;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			value_s1 <= value;
		end
	end

	// Packing: the new value lands right after the filled bits in a 16-bit
	// window; the upper byte is the byte under construction, the lower byte
	// holds bits that straddle into the next byte.
	always_comb begin
		total       = 5'(filled_q) + 5'(bps_eff);
		window      = {acc_q, 8'h00} | (16'(value_s1) << (5'd16 - total));
		column_next = column_q + 16'd1;
		eol         = column_next == width_eff;
		push        = '0;
		if (total >= 5'd8) begin
			push.a.packed_byte = window[15:8];
			filled_next        = 3'(total - 5'd8);
			acc_next           = window[7:0];
			push.a.end_of_line = eol && (filled_next == 3'd0);
			push.count         = 2'd1;
		end else begin
			filled_next = total[2:0];
			acc_next    = window[15:8];
		end
		// Line end flushes any leftover bits as a zero-padded byte.
		if (eol && filled_next != 3'd0) begin
			if (push.count == 2'd0) begin
				push.a.packed_byte = acc_next;
				push.a.end_of_line = 1'b1;
			end else begin
				push.b.packed_byte = acc_next;
				push.b.end_of_line = 1'b1;
			end
			push.count = push.count + 2'd1;
		end
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q        <= pdr_pkg::RST_BITS_PER_SAMPLE;
			width_q      <= pdr_pkg::RST_LINE_WIDTH;
			index_mode_q <= 1'b0;
			acc_q        <= '0;
			filled_q     <= '0;
			column_q     <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pdr_pkg::REG_BITS_PER_SAMPLE: bps_q        <= cfg_data[pdr_pkg::BpsWidth-1:0];
					pdr_pkg::REG_LINE_WIDTH:      width_q      <= cfg_data;
					pdr_pkg::REG_INDEX_MODE:      index_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				if (eol) begin
					acc_q    <= '0;
					filled_q <= '0;
					column_q <= '0;
				end else begin
					acc_q    <= acc_next;
					filled_q <= filled_next;
					column_q <= column_next;
				end
			end
		end
	end

	pdr_result_fifo u_result_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room_for_two (room_for_two),
		.out_valid    (m_axis_tvalid),
		.out_data     (head),
		.out_ready    (m_axis_tready)
	);

	assign m_axis_tdata = head.packed_byte;
	assign m_axis_tlast = head.end_of_line;

endmodule

`default_nettype wire

/* hdl/pdr_reduce.sv */
// Depth reduction of one 8-bit sample to bps bits (gray scaling or index truncation).
// Depends on pdr_pkg.
`default_nettype none

module pdr_reduce (
	input  wire logic [pdr_pkg::SampleWidth-1:0] sample,
	input  wire logic [pdr_pkg::BpsWidth-1:0]    bps,
	input  wire logic                            index_mode,
	output logic      [pdr_pkg::SampleWidth-1:0] value
);

	logic [8:0]  maxv_wide;
	logic [7:0]  maxv;
	logic [15:0] prod;
	logic [16:0] sum;

	// bps is already clamped to 1..8, so maxv fits in eight bits.
	always_comb begin
		maxv_wide = (9'd1 << bps) - 9'd1;
		maxv      = maxv_wide[7:0];
		prod      = 16'(sample) * 16'(maxv);
		// Division by 255 as multiply-by-reciprocal: exact for prod <= 255 * 255.
		sum       = 17'(prod) + 17'(prod[15:8]) + 17'd1;
		if (index_mode) begin
			value = sample & maxv;
		end else begin
			value = sum[15:8];
		end
	end

endmodule

`default_nettype wire

/* hdl/pdr_result_fifo.sv */
// Four-entry result queue that takes up to two results per cycle and gives one.
// Depends on pdr_pkg.
`default_nettype none

module pdr_result_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pdr_pkg::push_t  push,
	output logic                 room_for_two,
	output logic                 out_valid,
	output pdr_pkg::result_t     out_data,
	input  wire logic            out_ready
);

	pdr_pkg::result_t entry_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] wr_next;

	assign pop          = out_valid && out_ready;
	assign out_valid    = count_q != 3'd0;
	assign out_data     = entry_q[rd_ptr_q];
	assign room_for_two = count_q <= 3'd2;
	assign wr_next      = wr_ptr_q + 2'd1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.a;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_next] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + 3'(push.count) - 3'(pop);
		end
	end

endmodule

`default_nettype wire
